// ===== rtl/pid_integral_separation_clamp_unit_assert.svh =====
// ----------------------------------------------------------------------------
// PID integral separation clamp unit - assertion macros
// Shared concurrent assertion forms, clocked on aclk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef PID_INTEGRAL_SEPARATION_CLAMP_UNIT_ASSERT_SVH
`define PID_INTEGRAL_SEPARATION_CLAMP_UNIT_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define PISC_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("pisc assertion failed in the same cycle");

// Consequent must hold in the cycle after the antecedent.
`define PISC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("pisc assertion failed in the next cycle");

`endif

// ===== rtl/pisc_pkg.sv =====
// ----------------------------------------------------------------------------
// PID integral separation clamp - package
// Types, register indexes and constants shared by the unit's modules.
// ----------------------------------------------------------------------------
`default_nettype none

package pisc_pkg;

    localparam int unsigned PISC_DRIVE_OFFSET = 0;

    localparam int CFG_IDX_W = 4;
    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

    localparam cfg_idx_t REG_GAIN_P      = 4'd0;
    localparam cfg_idx_t REG_GAIN_I      = 4'd1;
    localparam cfg_idx_t REG_GAIN_D      = 4'd2;
    localparam cfg_idx_t REG_SEP_THR     = 4'd3;
    localparam cfg_idx_t REG_INT_UPPER   = 4'd4;
    localparam cfg_idx_t REG_INT_LOWER   = 4'd5;
    localparam cfg_idx_t REG_DRIVE_UPPER = 4'd6;
    localparam cfg_idx_t REG_DRIVE_LOWER = 4'd7;

    localparam logic signed [31:0] INT32_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] INT32_MIN = 32'sh8000_0000;
    localparam logic [15:0]        SEP_THR_RESET = 16'hFFFF;

    typedef struct packed {
        logic signed [15:0] gain_p;
        logic signed [15:0] gain_i;
        logic signed [15:0] gain_d;
        logic [15:0]        sep_thr;
        logic signed [31:0] int_upper;
        logic signed [31:0] int_lower;
        logic signed [31:0] drive_upper;
        logic signed [31:0] drive_lower;
    } pisc_cfg_t;

    // Error, measurement change and updated integral for one item.
    typedef struct packed {
        logic signed [16:0] err;
        logic signed [16:0] dmeas;
        logic signed [31:0] esum;
        logic               restart;
    } pisc_integ_t;

    // The three gain products for one item.
    typedef struct packed {
        logic signed [32:0] prod_p;
        logic signed [47:0] prod_i;
        logic signed [32:0] prod_d;
        logic               restart;
    } pisc_prod_t;

endpackage

`default_nettype wire

// ===== rtl/pisc_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// PID integral separation clamp - configuration registers
// Decodes register writes into the gain, threshold and limit registers.
// ----------------------------------------------------------------------------
`default_nettype none

module pisc_cfg_regs (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              cfg_valid,
    output logic                   cfg_ready,
    input  wire pisc_pkg::cfg_idx_t cfg_index,
    input  wire logic [31:0]       cfg_data,
    output pisc_pkg::pisc_cfg_t    cfg
);
    import pisc_pkg::*;

    pisc_cfg_t cfg_reg;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.gain_p      <= '0;
            cfg_reg.gain_i      <= '0;
            cfg_reg.gain_d      <= '0;
            cfg_reg.sep_thr     <= SEP_THR_RESET;
            cfg_reg.int_upper   <= INT32_MAX;
            cfg_reg.int_lower   <= INT32_MIN;
            cfg_reg.drive_upper <= INT32_MAX;
            cfg_reg.drive_lower <= INT32_MIN;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_GAIN_P:      cfg_reg.gain_p      <= cfg_data[15:0];
                REG_GAIN_I:      cfg_reg.gain_i      <= cfg_data[15:0];
                REG_GAIN_D:      cfg_reg.gain_d      <= cfg_data[15:0];
                REG_SEP_THR:     cfg_reg.sep_thr     <= cfg_data[15:0];
                REG_INT_UPPER:   cfg_reg.int_upper   <= cfg_data;
                REG_INT_LOWER:   cfg_reg.int_lower   <= cfg_data;
                REG_DRIVE_UPPER: cfg_reg.drive_upper <= cfg_data;
                REG_DRIVE_LOWER: cfg_reg.drive_lower <= cfg_data;
                default: ;
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== rtl/pisc_integ_stage.sv =====
// ----------------------------------------------------------------------------
// PID integral separation clamp - integral stage
// Forms the error, updates the separated and clamped integral and the last
// measurement, and registers the operands for the multiply stage.
// ----------------------------------------------------------------------------
`default_nettype none

module pisc_integ_stage (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire pisc_pkg::pisc_cfg_t  cfg,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire logic signed [15:0]   setpoint,
    input  wire logic signed [15:0]   measured,
    input  wire logic                 restart,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output pisc_pkg::pisc_integ_t     out_data
);
    import pisc_pkg::*;

    logic               valid_reg;
    pisc_integ_t        data_reg;
    logic signed [31:0] esum_reg;
    logic signed [31:0] esum_next;
    logic signed [15:0] last_meas_reg;
    logic signed [15:0] last_meas_next;

    logic signed [16:0] err;
    logic signed [16:0] dmeas;
    logic [16:0]        mag;
    logic signed [32:0] sum_wide;
    logic signed [31:0] sum_sat;
    logic signed [31:0] sum_sel;
    logic signed [31:0] sum_clamp;
    logic signed [31:0] lim_up;
    logic signed [31:0] lim_lo;
    logic               load;

    assign in_ready  = !valid_reg || out_ready;
    assign load      = in_valid && in_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_comb begin
        lim_up = cfg.int_upper;
        lim_lo = cfg.int_lower;

        err   = {setpoint[15], setpoint} - {measured[15], measured};
        dmeas = {measured[15], measured} - {last_meas_reg[15], last_meas_reg};
        mag   = err[16] ? 17'(-err) : 17'(err);

        // Add the error with saturation to the signed 32-bit range.
        sum_wide = {esum_reg[31], esum_reg} + {{16{err[16]}}, err};
        if (sum_wide[32] != sum_wide[31]) begin
            sum_sat = sum_wide[32] ? INT32_MIN : INT32_MAX;
        end else begin
            sum_sat = sum_wide[31:0];
        end

        // Integration pauses while the error magnitude is above the threshold.
        sum_sel = (mag <= {1'b0, cfg.sep_thr}) ? sum_sat : esum_reg;

        // Upper limit first, lower limit second: the lower one wins if crossed.
        sum_clamp = sum_sel;
        if (sum_clamp > lim_up) begin
            sum_clamp = lim_up;
        end
        if (sum_clamp < lim_lo) begin
            sum_clamp = lim_lo;
        end

        if (restart || (cfg.gain_i == 16'sd0)) begin
            esum_next = '0;
        end else begin
            esum_next = sum_clamp;
        end
        last_meas_next = restart ? 16'sd0 : measured;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg     <= 1'b0;
            esum_reg      <= '0;
            last_meas_reg <= '0;
        end else begin
            if (in_ready) begin
                valid_reg <= in_valid;
            end
            if (load) begin
                esum_reg      <= esum_next;
                last_meas_reg <= last_meas_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            data_reg.err     <= err;
            data_reg.dmeas   <= dmeas;
            data_reg.esum    <= esum_next;
            data_reg.restart <= restart;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/pisc_mult_stage.sv =====
// ----------------------------------------------------------------------------
// PID integral separation clamp - multiply stage
// Forms the proportional, integral and derivative products in parallel.
// ----------------------------------------------------------------------------
`default_nettype none

module pisc_mult_stage (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire pisc_pkg::pisc_cfg_t   cfg,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire pisc_pkg::pisc_integ_t in_data,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output pisc_pkg::pisc_prod_t       out_data
);
    import pisc_pkg::*;

    logic               valid_reg;
    pisc_prod_t         data_reg;

    logic signed [32:0] gp_ext;
    logic signed [32:0] err_ext;
    logic signed [47:0] gi_ext;
    logic signed [47:0] esum_ext;
    logic signed [32:0] gd_ext;
    logic signed [32:0] dm_ext;
    logic signed [32:0] prod_p;
    logic signed [47:0] prod_i;
    logic signed [32:0] prod_d;
    logic               load;

    assign in_ready  = !valid_reg || out_ready;
    assign load      = in_valid && in_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_comb begin
        gp_ext   = {{17{cfg.gain_p[15]}}, cfg.gain_p};
        err_ext  = {{16{in_data.err[16]}}, in_data.err};
        gi_ext   = {{32{cfg.gain_i[15]}}, cfg.gain_i};
        esum_ext = {{16{in_data.esum[31]}}, in_data.esum};
        gd_ext   = {{17{cfg.gain_d[15]}}, cfg.gain_d};
        dm_ext   = {{16{in_data.dmeas[16]}}, in_data.dmeas};
        prod_p   = gp_ext * err_ext;
        prod_i   = gi_ext * esum_ext;
        prod_d   = gd_ext * dm_ext;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            data_reg.prod_p  <= prod_p;
            data_reg.prod_i  <= prod_i;
            data_reg.prod_d  <= prod_d;
            data_reg.restart <= in_data.restart;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/pisc_drive_stage.sv =====
// ----------------------------------------------------------------------------
// PID integral separation clamp - drive stage
// Sums the products, scales by 2^-8, applies the offset and the drive limits,
// and holds the result beat.
// ----------------------------------------------------------------------------
`default_nettype none

module pisc_drive_stage #(
    parameter int unsigned DRIVE_OFFSET = pisc_pkg::PISC_DRIVE_OFFSET
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire pisc_pkg::pisc_cfg_t  cfg,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire pisc_pkg::pisc_prod_t in_data,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output logic [31:0]               drive
);
    import pisc_pkg::*;

    localparam logic signed [41:0] OFS = 42'(DRIVE_OFFSET);

    logic               valid_reg;
    logic [31:0]        drive_reg;
    logic [31:0]        drive_next;

    logic signed [48:0] acc;
    logic signed [40:0] scaled;
    logic signed [41:0] moved;
    logic signed [41:0] clamped;
    logic signed [41:0] lim_up;
    logic signed [41:0] lim_lo;
    logic               load;

    assign in_ready  = !valid_reg || out_ready;
    assign load      = in_valid && in_ready;
    assign out_valid = valid_reg;
    assign drive     = drive_reg;

    always_comb begin
        acc = {{16{in_data.prod_p[32]}}, in_data.prod_p}
            + {in_data.prod_i[47], in_data.prod_i}
            - {{16{in_data.prod_d[32]}}, in_data.prod_d};
        // Arithmetic shift by 8: floor division of the Q.8 sum.
        scaled = acc[48:8];

        // The offset pushes a nonzero result away from zero.
        if (scaled > 41'sd0) begin
            moved = {scaled[40], scaled} + OFS;
        end else if (scaled < 41'sd0) begin
            moved = {scaled[40], scaled} - OFS;
        end else begin
            moved = '0;
        end

        lim_up  = {{10{cfg.drive_upper[31]}}, cfg.drive_upper};
        lim_lo  = {{10{cfg.drive_lower[31]}}, cfg.drive_lower};
        clamped = moved;
        if (clamped > lim_up) begin
            clamped = lim_up;
        end
        if (clamped < lim_lo) begin
            clamped = lim_lo;
        end

        drive_next = in_data.restart ? 32'd0 : clamped[31:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            drive_reg <= drive_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/pid_integral_separation_clamp_unit.sv =====
// ----------------------------------------------------------------------------
// PID integral separation clamp unit - top level
// Positional PID controller with integral separation, integral and drive
// clamps, and derivative on measurement.
// ----------------------------------------------------------------------------
// Each input beat carries a setpoint and a measurement and produces exactly
// one drive beat, in order. The unit accepts a new beat every clock cycle
// while the result side does not stall, and a result passes through the
// input register, integral stage, multiply stage and drive register. Every
// stage has its own valid bit, so the input side keeps taking beats into
// empty stages while a finished drive waits to be taken. The integral and the
// last measurement are updated in the integral stage, one item per cycle
// while it is not stalled, and that feedback loop sets the clock rate
// together with the three parallel gain multiplies. A beat with tuser set
// (restart) clears the integral and the last measurement and yields a drive
// of zero. Configuration writes are taken at any time but must only be issued
// while no beats are in flight; writes to unknown indexes are dropped.
// ----------------------------------------------------------------------------
`default_nettype none

module pid_integral_separation_clamp_unit #(
    parameter int unsigned DRIVE_OFFSET = pisc_pkg::PISC_DRIVE_OFFSET
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    // Input stream.
    input  wire logic               s_tvalid,
    output logic                    s_tready,
    input  wire logic [31:0]        s_tdata,   // [15:0] setpoint, [31:16] measured
    input  wire logic               s_tuser,   // [0] restart
    // Result stream.
    output logic                    m_tvalid,
    input  wire logic               m_tready,
    output logic [31:0]             m_tdata,   // [31:0] drive
    // Configuration write channel.
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire pisc_pkg::cfg_idx_t cfg_index,
    input  wire logic [31:0]        cfg_data
);
    import pisc_pkg::*;

    pisc_cfg_t          cfg;

    // Input register.
    logic               in_valid_reg;
    logic signed [15:0] in_setpoint_reg;
    logic signed [15:0] in_measured_reg;
    logic               in_restart_reg;
    logic               s_load;

    logic               integ_ready;
    logic               integ_valid;
    pisc_integ_t        integ_data;
    logic               mult_ready;
    logic               mult_valid;
    pisc_prod_t         mult_data;
    logic               drive_ready;

    assign s_tready = !in_valid_reg || integ_ready;
    assign s_load   = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_load) begin
            in_setpoint_reg <= s_tdata[15:0];
            in_measured_reg <= s_tdata[31:16];
            in_restart_reg  <= s_tuser;
        end
    end

    pisc_cfg_regs u_cfg_regs (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    pisc_integ_stage u_integ_stage (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg),
        .in_valid  (in_valid_reg),
        .in_ready  (integ_ready),
        .setpoint  (in_setpoint_reg),
        .measured  (in_measured_reg),
        .restart   (in_restart_reg),
        .out_valid (integ_valid),
        .out_ready (mult_ready),
        .out_data  (integ_data)
    );

    pisc_mult_stage u_mult_stage (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg),
        .in_valid  (integ_valid),
        .in_ready  (mult_ready),
        .in_data   (integ_data),
        .out_valid (mult_valid),
        .out_ready (drive_ready),
        .out_data  (mult_data)
    );

    pisc_drive_stage #(
        .DRIVE_OFFSET (DRIVE_OFFSET)
    ) u_drive_stage (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg),
        .in_valid  (mult_valid),
        .in_ready  (drive_ready),
        .in_data   (mult_data),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .drive     (m_tdata)
    );

endmodule

`default_nettype wire

// ===== rtl/pisc_port_checker.sv =====
// ----------------------------------------------------------------------------
// PID integral separation clamp - port checker
// Concurrent checks on the top level's ports, attached by a bind statement.
// ----------------------------------------------------------------------------
`default_nettype none

`include "pid_integral_separation_clamp_unit_assert.svh"

module pisc_port_checker (
    input wire logic               aclk,
    input wire logic               aresetn,
    input wire logic               s_tvalid,
    input wire logic               s_tready,
    input wire logic [31:0]        s_tdata,
    input wire logic               s_tuser,
    input wire logic               m_tvalid,
    input wire logic               m_tready,
    input wire logic [31:0]        m_tdata,
    input wire logic               cfg_valid,
    input wire logic               cfg_ready,
    input wire pisc_pkg::cfg_idx_t cfg_index,
    input wire logic [31:0]        cfg_data
);
    import pisc_pkg::*;

    // Shadow copies of the drive limits, followed from the write channel.
    logic signed [31:0] lim_up_reg;
    logic signed [31:0] lim_lo_reg;
    logic signed [31:0] drive_s;
    logic               lim_ordered;
    logic               in_window;

    assign drive_s     = m_tdata;
    assign lim_ordered = (lim_lo_reg <= lim_up_reg);
    assign in_window   = (drive_s <= lim_up_reg) && (drive_s >= lim_lo_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lim_up_reg <= INT32_MAX;
            lim_lo_reg <= INT32_MIN;
        end else if (cfg_valid && cfg_ready) begin
            if (cfg_index == REG_DRIVE_UPPER) begin
                lim_up_reg <= cfg_data;
            end
            if (cfg_index == REG_DRIVE_LOWER) begin
                lim_lo_reg <= cfg_data;
            end
        end
    end

    // A stalled input beat holds until it is taken.
    `PISC_ASSERT_NEXT(a_input_holds, s_tvalid && !s_tready, s_tvalid && $stable(s_tdata) && $stable(s_tuser))

    // A stalled result beat holds.
    `PISC_ASSERT_NEXT(a_result_holds, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

    // With the result side ready every stage drains, so the input is ready too.
    `PISC_ASSERT_SAME(a_full_rate, m_tready, s_tready)

    // A drive beat lies within ordered drive limits, or is the restart zero.
    `PISC_ASSERT_SAME(a_drive_limits, m_tvalid && lim_ordered, in_window || (m_tdata == 32'd0))

endmodule

bind pid_integral_separation_clamp_unit pisc_port_checker u_pisc_port_checker (.*);

`default_nettype wire
